// File: hw/rtl/incoherent_dedispersion_sum_macros.svh
// Assertion helpers for the checker in ids_checker.sv.
`ifndef INCOHERENT_DEDISPERSION_SUM_MACROS_SVH
`define INCOHERENT_DEDISPERSION_SUM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDS_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ids_pkg.sv
package ids_pkg;

  localparam int CHANNELS  = 256;
  localparam int POOL_LEN  = 1024;
  localparam int DM_TRIALS = 256;

  localparam int OP_W    = 2;
  localparam int CHAN_W  = 8;
  localparam int TIME_W  = 10;
  localparam int SMP_W   = 16;
  localparam int FREQ_W  = 20;
  localparam int TRIAL_W = 8;
  localparam int SUMO_W  = 24;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 3;
  localparam int NCH_W   = 9;
  localparam int PLEN_W  = 11;

  localparam int CH_W    = $clog2(CHANNELS);
  localparam int TI_W    = $clog2(POOL_LEN);
  localparam int POOL_AW = CH_W + TI_W;
  localparam int POOL_D  = CHANNELS * POOL_LEN;

  localparam int DM_W    = 32;
  localparam int BASE_W  = 76;
  localparam int FSQ_W   = 2 * FREQ_W;
  localparam int CNT_W   = $clog2(BASE_W);
  localparam int SUM_W   = (SMP_W + CH_W + 1 > SUMO_W) ? SMP_W + CH_W + 1 : SUMO_W;

  localparam logic [BASE_W-1:0] DELAY_COEF = BASE_W'(64'd16210937500000);
  localparam logic [SUM_W-1:0]  SUM_MAX    = SUM_W'({SUMO_W{1'b1}});

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FREQ   = 2'd0,
    OP_LOAD_SAMPLE = 2'd1,
    OP_QUERY       = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_CHANNELS_USED = 3'd0,
    CFG_POOL_LEN_USED = 3'd1,
    CFG_DM_LOW        = 3'd2,
    CFG_DM_STEP       = 3'd3,
    CFG_SAMPLE_PERIOD = 3'd4
  } cfg_idx_t;

endpackage

// File: hw/rtl/ids_ram.sv
module ids_ram #(
  parameter int W = 16,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/incoherent_dedispersion_sum.sv
// Channel   Ports                                    Handshake
// input     in_op in_channel in_time_index in_sample  start high while busy low
//           in_freq_khz in_dm_index
// result    out_dm_sum out_time                       out_valid for one cycle
// config    cfg_index cfg_wdata                       cfg_we, written at once
// After reset the sample pool is cleared one entry a cycle, all 262144 entries, busy high.
// A load leaves busy low.
// A query runs one shared restoring divider, one quotient bit a cycle over 76 bits,
// twice per channel, after a 32-bit shift-add multiply.
// The result is shown in the first cycle that busy is low again; the receiver cannot stall it.
module incoherent_dedispersion_sum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ids_pkg::OP_W-1:0]    in_op,
  input  logic [ids_pkg::CHAN_W-1:0]  in_channel,
  input  logic [ids_pkg::TIME_W-1:0]  in_time_index,
  input  logic [ids_pkg::SMP_W-1:0]   in_sample,
  input  logic [ids_pkg::FREQ_W-1:0]  in_freq_khz,
  input  logic [ids_pkg::TRIAL_W-1:0] in_dm_index,
  output logic                        out_valid,
  output logic [ids_pkg::SUMO_W-1:0]  out_dm_sum,
  output logic [ids_pkg::TIME_W-1:0]  out_time,
  input  logic                        cfg_we,
  input  logic [ids_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ids_pkg::CFG_W-1:0]   cfg_wdata
);
  import ids_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_MUL   = 12'b0000_0000_0100,
    S_F_RD  = 12'b0000_0000_1000,
    S_F_SQ  = 12'b0000_0001_0000,
    S_F_DIV = 12'b0000_0010_0000,
    S_F_WR  = 12'b0000_0100_0000,
    S_D_RD  = 12'b0000_1000_0000,
    S_D_SUB = 12'b0001_0000_0000,
    S_S_DIV = 12'b0010_0000_0000,
    S_S_CHK = 12'b0100_0000_0000,
    S_S_ADD = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [NCH_W-1:0]  cfg_nch_r;
  logic [PLEN_W-1:0] cfg_plen_r;
  logic [CFG_W-1:0]  cfg_dm_low_r, cfg_dm_step_r, cfg_period_r;

  logic [POOL_AW-1:0] clr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CH_W:0]      ch_r, nch_r;
  logic [TI_W:0]      plen_r;
  logic [TI_W-1:0]    t_r;
  logic [DM_W-1:0]    dms_r;
  logic [BASE_W-1:0]  mc_r, base_r, nq_r, dmin_r;
  logic [FSQ_W-1:0]   dvs_r;
  logic [FSQ_W:0]     rem_r, rem_sh, rem_sub;
  logic               rem_ge, hit_r;
  logic [SUM_W-1:0]   sum_r, sum_add;
  logic [TI_W:0]      idx;
  logic [FREQ_W-1:0]  f_eff;
  logic               q_accept, last_ch;

  logic               fr_we, pl_we, dl_we;
  logic [CH_W-1:0]    fr_waddr, dl_addr;
  logic [FREQ_W-1:0]  fr_rdata;
  logic [POOL_AW-1:0] pl_waddr, pl_raddr;
  logic [SMP_W-1:0]   pl_wdata, pl_rdata;
  logic [BASE_W-1:0]  dl_rdata;

  assign busy     = (state_r != S_IDLE);
  assign q_accept = start && !busy && (in_op == OP_QUERY) &&
                    (32'(in_dm_index) < 32'(DM_TRIALS));
  assign last_ch  = ((ch_r + 1'b1) == nch_r);

  assign rem_sh  = {rem_r[FSQ_W-1:0], nq_r[BASE_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign f_eff   = (fr_rdata == '0) ? FREQ_W'(1) : fr_rdata;
  assign idx     = {1'b0, t_r} + nq_r[TI_W:0];
  assign sum_add = hit_r ? sum_r + SUM_W'(pl_rdata) : sum_r;

  // Memory ports.
  assign fr_we    = start && !busy && (in_op == OP_LOAD_FREQ) &&
                    (32'(in_channel) < 32'(CHANNELS));
  assign fr_waddr = CH_W'(in_channel);
  assign pl_we    = (state_r == S_CLEAR) || (start && !busy &&
                    (in_op == OP_LOAD_SAMPLE) && (32'(in_channel) < 32'(CHANNELS)) &&
                    (32'(in_time_index) < 32'(POOL_LEN)));
  assign pl_waddr = (state_r == S_CLEAR) ? clr_r :
                    {CH_W'(in_channel), TI_W'(in_time_index)};
  assign pl_wdata = (state_r == S_CLEAR) ? '0 : in_sample;
  assign pl_raddr = {ch_r[CH_W-1:0], idx[TI_W-1:0]};
  assign dl_we    = (state_r == S_F_WR);
  assign dl_addr  = ch_r[CH_W-1:0];

  ids_ram #(.W(FREQ_W), .D(CHANNELS)) u_freq (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(in_freq_khz),
    .raddr(ch_r[CH_W-1:0]), .rdata(fr_rdata)
  );

  ids_ram #(.W(SMP_W), .D(POOL_D)) u_pool (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  ids_ram #(.W(BASE_W), .D(CHANNELS)) u_delay (
    .clk(clk), .we(dl_we), .waddr(dl_addr), .wdata(nq_r),
    .raddr(dl_addr), .rdata(dl_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE:  if (q_accept) state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == CNT_W'(DM_W - 1)) state_nxt = (nch_r == '0) ? S_IDLE : S_F_RD;
      end
      S_F_RD:  state_nxt = S_F_SQ;
      S_F_SQ:  state_nxt = S_F_DIV;
      S_F_DIV: if (cnt_r == CNT_W'(BASE_W - 1)) state_nxt = S_F_WR;
      S_F_WR:  state_nxt = last_ch ? S_D_RD : S_F_RD;
      S_D_RD:  state_nxt = S_D_SUB;
      S_D_SUB: state_nxt = S_S_DIV;
      S_S_DIV: if (cnt_r == CNT_W'(BASE_W - 1)) state_nxt = S_S_CHK;
      S_S_CHK: state_nxt = S_S_ADD;
      S_S_ADD: state_nxt = last_ch ? S_IDLE : S_D_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      out_valid     <= 1'b0;
      cfg_nch_r     <= NCH_W'(256);
      cfg_plen_r    <= PLEN_W'(1024);
      cfg_dm_low_r  <= '0;
      cfg_dm_step_r <= CFG_W'(256);
      cfg_period_r  <= CFG_W'(250000);
    end else begin
      state_r   <= state_nxt;
      out_valid <= ((state_r == S_MUL) && (cnt_r == CNT_W'(DM_W - 1)) && (nch_r == '0)) ||
                   ((state_r == S_S_ADD) && last_ch);
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNELS_USED: cfg_nch_r     <= NCH_W'(cfg_wdata);
          CFG_POOL_LEN_USED: cfg_plen_r    <= PLEN_W'(cfg_wdata);
          CFG_DM_LOW:        cfg_dm_low_r  <= cfg_wdata;
          CFG_DM_STEP:       cfg_dm_step_r <= cfg_wdata;
          CFG_SAMPLE_PERIOD: cfg_period_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if ((state_r == S_MUL) && (cnt_r == CNT_W'(DM_W - 1)) && (nch_r == '0)) begin
        out_dm_sum <= '0;
        out_time   <= t_r;
      end
      if ((state_r == S_S_ADD) && last_ch) begin
        out_dm_sum <= (sum_add > SUM_MAX) ? '1 : sum_add[SUMO_W-1:0];
        out_time   <= t_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        t_r    <= in_time_index;
        dms_r  <= DM_W'(cfg_dm_low_r) + DM_W'(in_dm_index) * DM_W'(cfg_dm_step_r);
        mc_r   <= DELAY_COEF;
        base_r <= '0;
        cnt_r  <= '0;
        ch_r   <= '0;
        sum_r  <= '0;
        nch_r  <= (32'(cfg_nch_r) > 32'(CHANNELS)) ? (CH_W+1)'(CHANNELS)
                                                   : (CH_W+1)'(cfg_nch_r);
        plen_r <= (32'(cfg_plen_r) > 32'(POOL_LEN)) ? (TI_W+1)'(POOL_LEN)
                                                    : (TI_W+1)'(cfg_plen_r);
      end
      S_MUL: begin
        if (dms_r[0]) base_r <= base_r + mc_r;
        mc_r  <= {mc_r[BASE_W-2:0], 1'b0};
        dms_r <= {1'b0, dms_r[DM_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
      end
      S_F_SQ: begin
        dvs_r <= FSQ_W'(f_eff) * FSQ_W'(f_eff);
        nq_r  <= base_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_F_DIV, S_S_DIV: begin
        rem_r <= rem_ge ? rem_sub : rem_sh;
        nq_r  <= {nq_r[BASE_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      S_F_WR: begin
        if ((ch_r == '0) || (nq_r < dmin_r)) dmin_r <= nq_r;
        ch_r <= last_ch ? '0 : ch_r + 1'b1;
      end
      S_D_SUB: begin
        nq_r  <= dl_rdata - dmin_r;
        dvs_r <= (cfg_period_r == '0) ? FSQ_W'(1) : FSQ_W'(cfg_period_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_S_CHK: begin
        hit_r <= (nq_r < BASE_W'(plen_r)) && (idx < plen_r);
      end
      S_S_ADD: begin
        sum_r <= sum_add;
        ch_r  <= ch_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ids_checker.sv
`include "incoherent_dedispersion_sum_macros.svh"

module ids_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [ids_pkg::OP_W-1:0]    in_op,
  input logic [ids_pkg::TRIAL_W-1:0] in_dm_index,
  input logic                        out_valid
);
  import ids_pkg::*;

  // A result transaction is shown only once the sequencer has gone idle.
  `IDS_ASSERT_NOW(a_out_when_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // An idle cycle is never followed by a result, so each result is a single strobe.
  `IDS_ASSERT_NEXT(a_no_out_after_idle, clk, rst_n, !busy, !out_valid, "stray result")
  // An accepted query occupies the block.
  `IDS_ASSERT_NEXT(a_query_busy, clk, rst_n,
    start && !busy && (in_op == OP_QUERY) && (32'(in_dm_index) < 32'(DM_TRIALS)),
    busy, "query did not start")
  // Loads and ignored transactions leave the block idle in the cycle after.
  `IDS_ASSERT_NEXT(a_load_fast, clk, rst_n, start && !busy && (in_op != OP_QUERY),
    !busy, "load held the block")

endmodule

bind incoherent_dedispersion_sum ids_checker u_ids_checker (.*);
